[hdl/maa_pkg.sv]
package maa_pkg;

    localparam int unsigned MOD_BITS = 31;
    localparam int unsigned EXP_BITS = 63;

    localparam logic [MOD_BITS-1:0] MOD_RESET = 31'd1000000007;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_NOT_INV = 2'd2;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [MOD_BITS-1:0] operand_a;
        logic [MOD_BITS-1:0] operand_b;
        logic [EXP_BITS-1:0] exponent;
    } t_in_item;

    typedef struct packed {
        logic [MOD_BITS-1:0] result;
        logic [1:0]          status;
    } t_out_item;

endpackage

[hdl/maa_div.sv]
module maa_div #(
    parameter int W = 31
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_num,
    input  logic [W-1:0]   i_den,
    output logic           o_done,
    output logic [W-1:0]   o_quot,
    output logic [W-1:0]   o_rem
);

    localparam int CW = $clog2(2 * W);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [2*W-1:0] r_num;
    logic [W-1:0]  r_den, r_rem, r_quot;
    logic [W:0]    trial;
    logic          take;

    // One quotient bit per cycle, restoring form.
    assign trial = {r_rem, r_num[2*W-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(2 * W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[2*W-2:0], 1'b0};
            r_rem  <= take ? W'(trial - {1'b0, r_den}) : trial[W-1:0];
            r_quot <= {r_quot[W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[hdl/modular_arithmetic_unit.sv]
// Modular arithmetic unit over a modulus held in one configuration register.
// Input channel: i_in_valid / o_in_stall with an opcode, two operands and an
// exponent; a word is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with the result and a status.
// The block works on one word at a time and holds o_in_stall high from
// acceptance until its result has been taken.
// All reductions and products go through one shared restoring divider that
// retires one quotient bit per cycle. With a modulus of two or more every
// word first has both operands reduced; add and subtract then finish,
// multiply adds one modular product, power squares over the exponent bits
// up to its highest one and multiplies the accumulator at each one, and
// divide runs the Euclid steps and one product, or reports a zero or not
// invertible divisor without that product. A modulus below two answers on
// the next cycle. A new word can be taken once the result has been taken
// and the block is idle again.
// Reset loads the modulus with 1000000007 and returns to idle.
// When the receiver stalls, the result word is held unchanged and no new
// input word is accepted until it has been taken.
module modular_arithmetic_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [maa_pkg::MOD_BITS-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  maa_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output maa_pkg::t_out_item          o_out_data
);

    localparam int W = maa_pkg::MOD_BITS;
    localparam int E = maa_pkg::EXP_BITS;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RED_A = 13'b0000000000010,
        S_RED_B = 13'b0000000000100,
        S_MUL   = 13'b0000000001000,
        S_MDIV  = 13'b0000000010000,
        S_MWAIT = 13'b0000000100000,
        S_PSTEP = 13'b0000001000000,
        S_EDIV  = 13'b0000010000000,
        S_EWAIT = 13'b0000100000000,
        S_EMUL  = 13'b0001000000000,
        S_EUPD  = 13'b0010000000000,
        S_EFIN  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_FINAL = 2'd0,
        PH_ACC   = 2'd1,
        PH_SQ    = 2'd2
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [W-1:0]        r_mod, r_a, r_b, r_acc, r_sq, r_x, r_y;
    logic [W-1:0]        r_rm, r_ra, r_q, r_nr, r_res;
    logic [E-1:0]        r_exp;
    logic [2:0]          r_op;
    logic [1:0]          r_st;
    logic signed [W+1:0] r_clo, r_chi;
    logic signed [2*W+3:0] r_prod;

    logic                accept;
    logic                div_start, div_done;
    logic [2*W-1:0]      div_num;
    logic [W-1:0]        div_den, div_quot, div_rem;
    logic signed [W+1:0] mul_x, mul_y, mod_s, inv_s;
    logic [W:0]          sum, dif;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        div_start = 1'b0;
        div_num   = {{W{1'b0}}, i_in_data.operand_a[W-1:0]};
        div_den   = r_mod;
        case (r_state)
            S_IDLE: begin
                div_start = accept && (r_mod > W'(1));
            end
            S_RED_A: begin
                div_start = div_done;
                div_num   = {{W{1'b0}}, r_b};
            end
            S_MDIV: begin
                div_start = 1'b1;
                div_num   = r_prod[2*W-1:0];
            end
            S_EDIV: begin
                div_start = 1'b1;
                div_num   = {{W{1'b0}}, r_rm};
                div_den   = r_ra;
            end
            default: begin
            end
        endcase
    end

    maa_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // The one multiplier serves both modular products and Euclid coefficients.
    always_comb begin
        if (r_state == S_EMUL) begin
            mul_x = $signed({2'b00, r_q});
            mul_y = r_chi;
        end else begin
            mul_x = $signed({2'b00, r_x});
            mul_y = $signed({2'b00, r_y});
        end
    end

    assign mod_s = $signed({2'b00, r_mod});
    assign inv_s = (r_clo < 0) ? (r_clo + mod_s) : r_clo;
    assign sum   = {1'b0, r_a} + {1'b0, div_rem};
    assign dif   = (r_a >= div_rem) ? ({1'b0, r_a} - {1'b0, div_rem})
                                    : ({1'b0, r_a} + {1'b0, r_mod} - {1'b0, div_rem});

    always_ff @(posedge i_clk) begin
        r_prod <= mul_x * mul_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= maa_pkg::MOD_RESET;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= i_in_data.opcode;
                        r_b   <= i_in_data.operand_b[W-1:0];
                        r_exp <= i_in_data.exponent[E-1:0];
                        if (r_mod > W'(1)) begin
                            r_state <= S_RED_A;
                        end else begin
                            r_res   <= '0;
                            r_st    <= (i_in_data.opcode == maa_pkg::OP_DIV) ?
                                       maa_pkg::ST_DIV0 : maa_pkg::ST_OK;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RED_A: begin
                    if (div_done) begin
                        r_a     <= div_rem;
                        r_state <= S_RED_B;
                    end
                end
                S_RED_B: begin
                    if (div_done) begin
                        r_b   <= div_rem;
                        r_st  <= maa_pkg::ST_OK;
                        r_res <= '0;
                        r_state <= S_OUT;
                        case (r_op)
                            maa_pkg::OP_ADD: begin
                                r_res <= (sum >= {1'b0, r_mod}) ?
                                         W'(sum - {1'b0, r_mod}) : sum[W-1:0];
                            end
                            maa_pkg::OP_SUB: begin
                                r_res <= dif[W-1:0];
                            end
                            maa_pkg::OP_MUL: begin
                                r_x     <= r_a;
                                r_y     <= div_rem;
                                r_phase <= PH_FINAL;
                                r_state <= S_MUL;
                            end
                            maa_pkg::OP_DIV: begin
                                if (div_rem == '0) begin
                                    r_st <= maa_pkg::ST_DIV0;
                                end else begin
                                    r_rm    <= r_mod;
                                    r_ra    <= div_rem;
                                    r_clo   <= '0;
                                    r_chi   <= (W+2)'(1);
                                    r_state <= S_EDIV;
                                end
                            end
                            maa_pkg::OP_POW: begin
                                r_acc   <= W'(1);
                                r_sq    <= r_a;
                                r_state <= S_PSTEP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (div_done) begin
                        case (r_phase)
                            PH_ACC: begin
                                r_acc   <= div_rem;
                                r_x     <= r_sq;
                                r_y     <= r_sq;
                                r_phase <= PH_SQ;
                                r_state <= S_MUL;
                            end
                            PH_SQ: begin
                                r_sq    <= div_rem;
                                r_exp   <= r_exp >> 1;
                                r_state <= S_PSTEP;
                            end
                            default: begin
                                r_res   <= div_rem;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_PSTEP: begin
                    if (r_exp == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_OUT;
                    end else begin
                        r_x     <= r_exp[0] ? r_acc : r_sq;
                        r_y     <= r_sq;
                        r_phase <= r_exp[0] ? PH_ACC : PH_SQ;
                        r_state <= S_MUL;
                    end
                end
                S_EDIV: begin
                    r_state <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (div_done) begin
                        r_q     <= div_quot;
                        r_nr    <= div_rem;
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    r_state <= S_EUPD;
                end
                S_EUPD: begin
                    r_rm    <= r_ra;
                    r_ra    <= r_nr;
                    r_clo   <= r_chi;
                    r_chi   <= r_clo - r_prod[W+1:0];
                    r_state <= (r_nr == '0) ? S_EFIN : S_EDIV;
                end
                S_EFIN: begin
                    if (r_rm != W'(1)) begin
                        r_res   <= '0;
                        r_st    <= maa_pkg::ST_NOT_INV;
                        r_state <= S_OUT;
                    end else begin
                        r_x     <= r_a;
                        r_y     <= inv_s[W-1:0];
                        r_phase <= PH_FINAL;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = {r_res, r_st};

endmodule

[hdl/maa_chk.sv]
module maa_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input maa_pkg::t_out_item o_out_data
);

    // A result word stays up and unchanged while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed under stall");

    // No new input word is taken while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // After acceptance the block is busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == maa_pkg::ST_OK ||
                         o_out_data.status == maa_pkg::ST_DIV0 ||
                         o_out_data.status == maa_pkg::ST_NOT_INV))
        else $error("bad status code");

endmodule

bind modular_arithmetic_unit maa_chk u_maa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
